// ===== rtl/lvmf_pkg.sv =====
// Shared types and constants for the label volume majority filter.
package lvmf_pkg;

  // Field and register widths
  localparam int DATA_W    = 16;
  localparam int PLANE_W   = 13;
  localparam int ROW_W     = 9;
  localparam int COL_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int PSIZE_W   = ROW_W + COL_W;
  localparam int POS_W     = PSIZE_W + PLANE_W;
  localparam int LAG_W     = PSIZE_W + 1;

  // Vote bookkeeping: 27 neighbours plus the centre slot
  localparam int SLOTS  = 28;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 5;

  // Input opcodes
  localparam logic OP_VOXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] voxel_label;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] filtered_label;
    logic              volume_end;
  } result_t;

  // Command passed from the front to the back through the queue
  typedef struct packed {
    logic              wr;
    logic              emit;
    logic              last;
    logic [DATA_W-1:0] label;
  } cmd_t;

  // Volume geometry and control shared by front and back
  typedef struct packed {
    logic [PLANE_W-1:0] planes;
    logic [ROW_W-1:0]   rows;
    logic [COL_W-1:0]   cols;
    logic [PSIZE_W-1:0] psize;
    logic [POS_W-1:0]   total;
    logic [LAG_W-1:0]   lag;
    logic               restart;
    logic               hold;
  } geom_t;

endpackage

// ===== rtl/label_volume_majority_filter_unit.sv =====
// Top level of the 3x3x3 majority filter over a streamed label volume.
//
// Voxels arrive in raster order (plane, row, column); each result is the most
// frequent nonzero label in the voxel's in-bounds 3x3x3 neighbourhood, centre
// wins ties, then first in scan order; background passes as 0. Results lag
// by one plane plus one row plus one voxel; drain requests release the rest.
// A front end accepts requests into a two-entry command queue, so requests keep
// flowing while a result waits, until the queue fills. For a voxel that releases
// an output with a nonzero centre the back end pops the command, writes the
// store, reads the centre and waits for it, makes 27 neighbour reads through the
// single read port of the label store, drains the read pipeline and presents the
// result; a drain skips the write, a background centre skips the neighbour
// reads, a voxel that releases no output is only popped and written, and a
// stalled result holds the back end. The label store holds
// 2*MAX_ROWS*MAX_COLUMNS + 2*MAX_COLUMNS + 3 entries and needs no clearing. A
// write to the planes, rows or columns register restarts the stream and holds
// off requests while plane size, volume size and lag are recomputed.
module label_volume_majority_filter_unit #(
  parameter int LABEL_BITS  = 16,
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_PLANES  = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  lvmf_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output lvmf_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [lvmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lvmf_pkg::CFG_W-1:0]        cfg_data
);

  logic [lvmf_pkg::PLANE_W-1:0] planes;
  logic [lvmf_pkg::ROW_W-1:0]   rows;
  logic [lvmf_pkg::COL_W-1:0]   cols;
  logic [lvmf_pkg::PSIZE_W-1:0] psize;
  logic [lvmf_pkg::POS_W-1:0]   total;
  logic [lvmf_pkg::LAG_W-1:0]   lag;
  logic [1:0]                   settle;
  logic                         restart;
  logic [lvmf_pkg::PLANE_W-1:0] planes_in;
  logic [lvmf_pkg::ROW_W-1:0]   rows_in;
  logic [lvmf_pkg::COL_W-1:0]   cols_in;
  lvmf_pkg::geom_t              geom;

  logic           push_valid;
  logic           push_ready;
  lvmf_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  lvmf_pkg::cmd_t pop_cmd;

  // Clamp written values into their legal ranges
  always_comb begin
    planes_in = cfg_data[lvmf_pkg::PLANE_W-1:0];
    rows_in   = cfg_data[lvmf_pkg::ROW_W-1:0];
    cols_in   = cfg_data[lvmf_pkg::COL_W-1:0];
    if (planes_in == '0) begin
      planes_in = lvmf_pkg::PLANE_W'(1);
    end else if (32'(planes_in) > 32'(MAX_PLANES)) begin
      planes_in = lvmf_pkg::PLANE_W'(MAX_PLANES);
    end
    if (rows_in == '0) begin
      rows_in = lvmf_pkg::ROW_W'(1);
    end else if (32'(rows_in) > 32'(MAX_ROWS)) begin
      rows_in = lvmf_pkg::ROW_W'(MAX_ROWS);
    end
    if (cols_in == '0) begin
      cols_in = lvmf_pkg::COL_W'(1);
    end else if (32'(cols_in) > 32'(MAX_COLUMNS)) begin
      cols_in = lvmf_pkg::COL_W'(MAX_COLUMNS);
    end
  end

  // Decode register writes
  always_comb begin
    unique case (cfg_index)
      lvmf_pkg::CFG_PLANES, lvmf_pkg::CFG_ROWS, lvmf_pkg::CFG_COLS: begin
        restart = cfg_we;
      end
      default: begin
        restart = 1'b0;
      end
    endcase
  end

  // Hold configuration and derived geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= lvmf_pkg::PLANE_W'(1);
      rows   <= lvmf_pkg::ROW_W'(1);
      cols   <= lvmf_pkg::COL_W'(1);
      psize  <= lvmf_pkg::PSIZE_W'(1);
      total  <= lvmf_pkg::POS_W'(1);
      lag    <= lvmf_pkg::LAG_W'(3);
      settle <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lvmf_pkg::CFG_PLANES: planes <= planes_in;
          lvmf_pkg::CFG_ROWS:   rows   <= rows_in;
          lvmf_pkg::CFG_COLS:   cols   <= cols_in;
          default: begin
          end
        endcase
      end
      psize <= lvmf_pkg::PSIZE_W'(rows) * lvmf_pkg::PSIZE_W'(cols);
      total <= lvmf_pkg::POS_W'(psize) * lvmf_pkg::POS_W'(planes);
      lag   <= lvmf_pkg::LAG_W'(psize) + lvmf_pkg::LAG_W'(cols) + lvmf_pkg::LAG_W'(1);
      if (restart) begin
        settle <= 2'd2;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  assign geom.planes  = planes;
  assign geom.rows    = rows;
  assign geom.cols    = cols;
  assign geom.psize   = psize;
  assign geom.total   = total;
  assign geom.lag     = lag;
  assign geom.restart = restart;
  assign geom.hold    = (settle != 2'd0) || restart;

  lvmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lvmf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lvmf_back #(
    .LABEL_BITS  (LABEL_BITS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/lvmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lvmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lvmf_queue.sv =====
// Two-entry command queue between the front and the back.
module lvmf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  lvmf_pkg::cmd_t    push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lvmf_pkg::cmd_t    pop_cmd
);

  lvmf_pkg::cmd_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slot[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/lvmf_front.sv =====
// Front end: accepts requests, tracks stream positions and issues commands.
module lvmf_front (
  input  logic              clk,
  input  logic              rst,
  input  lvmf_pkg::geom_t   geom,
  input  logic              item_valid,
  output logic              item_ready,
  input  lvmf_pkg::item_t   item,
  output logic              push_valid,
  input  logic              push_ready,
  output lvmf_pkg::cmd_t    push_cmd
);

  logic [lvmf_pkg::POS_W-1:0] in_pos;
  logic [lvmf_pkg::POS_W-1:0] out_pos;
  logic [lvmf_pkg::POS_W-1:0] in_pos_next;
  logic [lvmf_pkg::POS_W-1:0] out_pos_inc;
  logic [lvmf_pkg::POS_W:0]   emit_mark;
  logic                       wr;
  logic                       emit;
  logic                       last;
  logic                       accept;

  assign item_ready = push_ready && !geom.hold;
  assign accept     = item_valid && item_ready;
  assign out_pos_inc = out_pos + lvmf_pkg::POS_W'(1);
  assign emit_mark  = {1'b0, out_pos} + (lvmf_pkg::POS_W + 1)'(geom.lag);

  // Classify the request
  always_comb begin
    wr          = 1'b0;
    emit        = 1'b0;
    in_pos_next = in_pos;
    if (item.opcode == lvmf_pkg::OP_VOXEL) begin
      if (in_pos < geom.total) begin
        wr          = 1'b1;
        in_pos_next = in_pos + lvmf_pkg::POS_W'(1);
        emit        = ({1'b0, in_pos_next} > emit_mark);
      end
    end else begin
      emit = (in_pos == geom.total) && (out_pos < geom.total);
    end
    last = emit && (out_pos_inc == geom.total);
  end

  assign push_valid     = item_valid && !geom.hold && (wr || emit);
  assign push_cmd.wr    = wr;
  assign push_cmd.emit  = emit;
  assign push_cmd.last  = last;
  assign push_cmd.label = item.voxel_label;

  // Track positions; restart after the last output or a register write
  always_ff @(posedge clk) begin
    if (rst || geom.restart) begin
      in_pos  <= '0;
      out_pos <= '0;
    end else if (accept) begin
      if (last) begin
        in_pos  <= '0;
        out_pos <= '0;
      end else begin
        in_pos <= in_pos_next;
        if (emit) begin
          out_pos <= out_pos_inc;
        end
      end
    end
  end

endmodule

// ===== rtl/lvmf_back.sv =====
// Back end: writes the label store and runs the neighbourhood vote.
module lvmf_back #(
  parameter int LABEL_BITS  = 16,
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  lvmf_pkg::geom_t   geom,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lvmf_pkg::cmd_t    pop_cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output lvmf_pkg::result_t result
);

  localparam int DEPTH   = 2 * MAX_ROWS * MAX_COLUMNS + 2 * MAX_COLUMNS + 3;
  localparam int AW      = $clog2(DEPTH);
  localparam int STORE_W = (LABEL_BITS < lvmf_pkg::DATA_W) ? LABEL_BITS : lvmf_pkg::DATA_W;
  localparam int OFF_W   = AW + 2;
  localparam logic signed [OFF_W-1:0] DEPTH_S = OFF_W'(DEPTH);
  localparam logic signed [OFF_W-1:0] ONE_S   = OFF_W'(1);
  localparam logic signed [OFF_W-1:0] TWO_S   = OFF_W'(2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_CENTRE = 3'd2;
  localparam logic [2:0] S_CWAIT  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic [1:0] D_NEG = 2'd0;
  localparam logic [1:0] D_MID = 2'd1;
  localparam logic [1:0] D_POS = 2'd2;

  logic [2:0]                   state;
  lvmf_pkg::cmd_t               cmd;
  logic [AW-1:0]                wptr;
  logic [AW-1:0]                cptr;
  logic [lvmf_pkg::COL_W-1:0]   col;
  logic [lvmf_pkg::ROW_W-1:0]   row;
  logic [lvmf_pkg::PLANE_W-1:0] plane;
  logic [1:0]                   dp;
  logic [1:0]                   dr;
  logic [1:0]                   dc;
  logic                         scan_done;
  logic                         pend;
  logic signed [OFF_W-1:0]      off;
  logic [STORE_W-1:0]           slot_lab [lvmf_pkg::SLOTS];
  logic [lvmf_pkg::CNT_W-1:0]   slot_cnt [lvmf_pkg::SLOTS];
  logic [lvmf_pkg::SLOT_W-1:0]  nslot;
  logic [lvmf_pkg::SLOT_W-1:0]  best;
  logic [lvmf_pkg::CNT_W-1:0]   best_cnt;
  lvmf_pkg::result_t            res;

  logic                         ram_we;
  logic [AW-1:0]                raddr;
  logic [STORE_W-1:0]           rdata;
  logic [STORE_W-1:0]           wdata;

  logic signed [OFF_W-1:0]      cols_s;
  logic signed [OFF_W-1:0]      psize_s;
  logic signed [OFF_W-1:0]      lag_s;
  logic signed [OFF_W-1:0]      step_row;
  logic signed [OFF_W-1:0]      step_plane;
  logic signed [OFF_W-1:0]      nsum;
  logic signed [OFF_W-1:0]      nfix;
  logic [AW-1:0]                naddr;
  logic                         inb;
  logic                         pl_first;
  logic                         pl_last;
  logic                         r_first;
  logic                         r_last;
  logic                         c_first;
  logic                         c_last;
  logic [AW-1:0]                wptr_inc;
  logic [AW-1:0]                cptr_inc;

  logic [lvmf_pkg::SLOTS-1:0]   hit;
  logic                         found;
  logic [lvmf_pkg::SLOT_W-1:0]  q;
  logic [lvmf_pkg::CNT_W-1:0]   newcnt;

  lvmf_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign wdata        = cmd.label[STORE_W-1:0];
  assign ram_we       = (state == S_WRITE);
  assign pop_ready    = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign result       = res;

  assign wptr_inc = (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
  assign cptr_inc = (cptr == AW'(DEPTH - 1)) ? '0 : cptr + AW'(1);

  // Offset steps through the 3x3x3 scan
  assign cols_s     = $signed(OFF_W'(geom.cols));
  assign psize_s    = $signed(OFF_W'(geom.psize));
  assign lag_s      = $signed(OFF_W'(geom.lag));
  assign step_row   = cols_s - TWO_S;
  assign step_plane = psize_s - cols_s - cols_s - TWO_S;

  // Wrap the neighbour address into the circular store
  always_comb begin
    nsum = $signed({2'b00, cptr}) + off;
    if (nsum[OFF_W-1]) begin
      nfix = nsum + DEPTH_S;
    end else if (nsum >= DEPTH_S) begin
      nfix = nsum - DEPTH_S;
    end else begin
      nfix = nsum;
    end
    naddr = nfix[AW-1:0];
  end

  assign raddr = (state == S_SCAN) ? naddr : cptr;

  // Bounds of the current neighbour
  assign pl_first = (plane == '0);
  assign pl_last  = (plane == geom.planes - lvmf_pkg::PLANE_W'(1));
  assign r_first  = (row == '0);
  assign r_last   = (row == geom.rows - lvmf_pkg::ROW_W'(1));
  assign c_first  = (col == '0);
  assign c_last   = (col == geom.cols - lvmf_pkg::COL_W'(1));
  assign inb = !((dp == D_NEG) && pl_first) && !((dp == D_POS) && pl_last) &&
               !((dr == D_NEG) && r_first)  && !((dr == D_POS) && r_last)  &&
               !((dc == D_NEG) && c_first)  && !((dc == D_POS) && c_last);

  // Look up the arriving label among the slots seen so far
  always_comb begin
    found = 1'b0;
    q     = nslot;
    for (int i = 0; i < lvmf_pkg::SLOTS; i++) begin
      hit[i] = (lvmf_pkg::SLOT_W'(i) < nslot) && (slot_lab[i] == rdata);
    end
    for (int i = lvmf_pkg::SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        q     = lvmf_pkg::SLOT_W'(i);
      end
    end
    newcnt = found ? slot_cnt[q] + lvmf_pkg::CNT_W'(1) : lvmf_pkg::CNT_W'(1);
  end

  // Vote slots and result payload
  always_ff @(posedge clk) begin
    if (state == S_CWAIT) begin
      slot_lab[0] <= rdata;
      slot_cnt[0] <= '0;
      best_cnt    <= '0;
      res.filtered_label <= '0;
      res.volume_end     <= cmd.last;
    end
    if ((state == S_SCAN) && pend && (rdata != '0)) begin
      if (!found) begin
        slot_lab[q] <= rdata;
      end
      slot_cnt[q] <= newcnt;
      if ((newcnt > best_cnt) || ((newcnt == best_cnt) && (q < best))) begin
        best_cnt <= newcnt;
      end
    end
    if ((state == S_SCAN) && scan_done && !pend) begin
      res.filtered_label <= lvmf_pkg::DATA_W'(slot_lab[best]);
    end
  end

  // Sequencer: write, read centre, scan neighbours, present result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wptr      <= '0;
      cptr      <= '0;
      col       <= '0;
      row       <= '0;
      plane     <= '0;
      pend      <= 1'b0;
      scan_done <= 1'b1;
      nslot     <= '0;
      best      <= '0;
      dp        <= D_NEG;
      dr        <= D_NEG;
      dc        <= D_NEG;
      off       <= '0;
      cmd       <= '0;
    end else if (geom.restart) begin
      wptr  <= '0;
      cptr  <= '0;
      col   <= '0;
      row   <= '0;
      plane <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cmd   <= pop_cmd;
            state <= pop_cmd.wr ? S_WRITE : S_CENTRE;
          end
        end
        S_WRITE: begin
          wptr  <= wptr_inc;
          state <= cmd.emit ? S_CENTRE : S_IDLE;
        end
        S_CENTRE: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (rdata == '0) begin
            state <= S_OUT;
          end else begin
            nslot     <= lvmf_pkg::SLOT_W'(1);
            best      <= '0;
            dp        <= D_NEG;
            dr        <= D_NEG;
            dc        <= D_NEG;
            off       <= -lag_s;
            scan_done <= 1'b0;
            pend      <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // consume the label read in the previous cycle
          if (pend && (rdata != '0)) begin
            if (!found) begin
              nslot <= nslot + lvmf_pkg::SLOT_W'(1);
            end
            if ((newcnt > best_cnt) || ((newcnt == best_cnt) && (q < best))) begin
              best <= q;
            end
          end
          // issue the next neighbour read
          if (!scan_done) begin
            pend <= inb;
            if (dc == D_POS) begin
              dc <= D_NEG;
              if (dr == D_POS) begin
                dr <= D_NEG;
                if (dp == D_POS) begin
                  scan_done <= 1'b1;
                end else begin
                  dp  <= dp + 2'd1;
                  off <= off + step_plane;
                end
              end else begin
                dr  <= dr + 2'd1;
                off <= off + step_row;
              end
            end else begin
              dc  <= dc + 2'd1;
              off <= off + ONE_S;
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (result_ready) begin
            state <= S_IDLE;
            if (cmd.last) begin
              wptr  <= '0;
              cptr  <= '0;
              col   <= '0;
              row   <= '0;
              plane <= '0;
            end else begin
              cptr <= cptr_inc;
              if (c_last) begin
                col <= '0;
                if (r_last) begin
                  row   <= '0;
                  plane <= plane + lvmf_pkg::PLANE_W'(1);
                end else begin
                  row <= row + lvmf_pkg::ROW_W'(1);
                end
              end else begin
                col <= col + lvmf_pkg::COL_W'(1);
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
